### rtl/vlrp_pkg.sv
// ----------------------------------------------------------------------------
// vlrp_pkg
// Shared types and constants of the video line RTP packetizer.
// ----------------------------------------------------------------------------
`default_nettype none

package vlrp_pkg;

    // Parameter defaults.
    localparam int DEF_MAX_WIDTH      = 4096;
    localparam int DEF_MAX_HEIGHT     = 4096;
    localparam int DEF_PAYLOAD_BUDGET = 1376;

    // Field widths fixed by the packet header format.
    localparam int TS_W   = 32;
    localparam int SEQ_W  = 32;
    localparam int HALF_W = 16;
    localparam int LEN_W  = 11;
    localparam int ROW_W  = 12;
    localparam int POS_W  = 12;
    localparam int OFS_W  = 26;
    localparam int DIM_W  = 13;
    localparam int BPP_W  = 3;
    localparam int PT_W   = 7;
    localparam int SSRC_W = 32;
    localparam int CNT_W  = 4;

    localparam int HEADER_BYTES = 20;
    localparam int MAX_PACKETS  = 12;

    // APB register map.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_BPP          = 3'd2,
        REG_PAYLOAD_TYPE = 3'd3,
        REG_SOURCE_ID    = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROW_MUL,
        ST_BASE_MUL,
        ST_PKT
    } state_t;

    typedef struct packed {
        logic [DIM_W-1:0] frame_width;
        logic [DIM_W-1:0] frame_height;
        logic [BPP_W-1:0] bpp;
    } cfg_t;

    // Sequencer to datapath.
    typedef struct packed {
        logic accept;
        logic row_mul;
        logic base_mul;
        logic emit;
        logic finish;
    } ctrl_t;

    // Datapath to sequencer.
    typedef struct packed {
        logic more;
        logic out_space;
    } stat_t;

endpackage

`default_nettype wire

### rtl/vlrp_line_if.sv
// ----------------------------------------------------------------------------
// vlrp_line_if
// Input channel: one request per video line, carrying the frame timestamp.
// ----------------------------------------------------------------------------
`default_nettype none

interface vlrp_line_if
    import vlrp_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [TS_W-1:0] frame_timestamp;

    modport source (output valid, output frame_timestamp, input ready);
    modport sink (input valid, input frame_timestamp, output ready);
endinterface

`default_nettype wire

### rtl/vlrp_pkt_if.sv
// ----------------------------------------------------------------------------
// vlrp_pkt_if
// Output channel: one request per packet, carrying its header fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface vlrp_pkt_if
    import vlrp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              marker;
    logic [HALF_W-1:0] seq_low;
    logic [HALF_W-1:0] seq_high;
    logic [TS_W-1:0]   timestamp;
    logic [LEN_W-1:0]  payload_length;
    logic [ROW_W-1:0]  line_number;
    logic [POS_W-1:0]  pixel_offset;
    logic [OFS_W-1:0]  source_offset;
    logic [LEN_W-1:0]  packet_bytes;
    logic              last_of_line;

    modport source (
        output valid, output marker, output seq_low, output seq_high,
        output timestamp, output payload_length, output line_number,
        output pixel_offset, output source_offset, output packet_bytes,
        output last_of_line, input ready
    );
    modport sink (
        input valid, input marker, input seq_low, input seq_high,
        input timestamp, input payload_length, input line_number,
        input pixel_offset, input source_offset, input packet_bytes,
        input last_of_line, output ready
    );
endinterface

`default_nettype wire

### rtl/vlrp_regs.sv
// ----------------------------------------------------------------------------
// vlrp_regs
// APB register file: frame geometry, pixel size and RTP identity fields.
// ----------------------------------------------------------------------------
`default_nettype none

module vlrp_regs
    import vlrp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output cfg_t                       cfg
);

    logic [DIM_W-1:0]  width_reg, width_next;
    logic [DIM_W-1:0]  height_reg, height_next;
    logic [BPP_W-1:0]  bpp_reg, bpp_next;
    logic [PT_W-1:0]   ptype_reg, ptype_next;
    logic [SSRC_W-1:0] ssrc_reg, ssrc_next;
    reg_idx_t          idx;
    logic              wr;

    assign idx = reg_idx_t'(paddr[4:2]);
    assign wr  = psel && penable && pwrite;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        bpp_next    = bpp_reg;
        ptype_next  = ptype_reg;
        ssrc_next   = ssrc_reg;
        if (wr)
        begin
            unique case (idx)
                REG_FRAME_WIDTH:  width_next  = pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT: height_next = pwdata[DIM_W-1:0];
                REG_BPP:          bpp_next    = pwdata[BPP_W-1:0];
                REG_PAYLOAD_TYPE: ptype_next  = pwdata[PT_W-1:0];
                REG_SOURCE_ID:    ssrc_next   = pwdata[SSRC_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(height_reg);
            REG_BPP:          prdata = APB_DATA_W'(bpp_reg);
            REG_PAYLOAD_TYPE: prdata = APB_DATA_W'(ptype_reg);
            REG_SOURCE_ID:    prdata = APB_DATA_W'(ssrc_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(1920);
            height_reg <= DIM_W'(1080);
            bpp_reg    <= BPP_W'(2);
            ptype_reg  <= PT_W'(96);
            ssrc_reg   <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            bpp_reg    <= bpp_next;
            ptype_reg  <= ptype_next;
            ssrc_reg   <= ssrc_next;
        end
    end

    assign cfg.frame_width  = width_reg;
    assign cfg.frame_height = height_reg;
    assign cfg.bpp          = bpp_reg;

endmodule

`default_nettype wire

### rtl/vlrp_seq.sv
// ----------------------------------------------------------------------------
// vlrp_seq
// Sequencer: steps the shared multiplier through row, base and packet work.
// ----------------------------------------------------------------------------
`default_nettype none

module vlrp_seq
    import vlrp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  stat_t      stat,
    output ctrl_t      ctrl
);

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (in_valid) state_next = ST_ROW_MUL;
            ST_ROW_MUL:  state_next = ST_BASE_MUL;
            ST_BASE_MUL: state_next = ST_PKT;
            ST_PKT:      if (!stat.more) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl     = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                ctrl.accept = in_valid;
            end
            ST_ROW_MUL:  ctrl.row_mul = 1'b1;
            ST_BASE_MUL: ctrl.base_mul = 1'b1;
            ST_PKT:
            begin
                ctrl.emit   = stat.more && stat.out_space;
                ctrl.finish = !stat.more;
            end
            default:     ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

### rtl/vlrp_dp.sv
// ----------------------------------------------------------------------------
// vlrp_dp
// Datapath: line and sequence counters, one shared multiplier, packet fields.
// ----------------------------------------------------------------------------
`default_nettype none

module vlrp_dp
    import vlrp_pkg::*;
#(
    parameter int MAX_WIDTH      = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT     = DEF_MAX_HEIGHT,
    parameter int PAYLOAD_BUDGET = DEF_PAYLOAD_BUDGET
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  cfg_t                 cfg,
    input  ctrl_t                ctrl,
    output stat_t                stat,
    input  wire logic [TS_W-1:0] frame_timestamp,
    vlrp_pkt_if.source           pkt
);

    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int XW = (WB > DIM_W) ? WB : DIM_W;
    localparam int HB = $clog2(MAX_HEIGHT + 1);
    localparam int HW = (HB > DIM_W) ? HB : DIM_W;

    // Whole pixels per packet for each pixel size.
    localparam logic [LEN_W-1:0] MP1 = LEN_W'(PAYLOAD_BUDGET / 1);
    localparam logic [LEN_W-1:0] MP2 = LEN_W'(PAYLOAD_BUDGET / 2);
    localparam logic [LEN_W-1:0] MP3 = LEN_W'(PAYLOAD_BUDGET / 3);
    localparam logic [LEN_W-1:0] MP4 = LEN_W'(PAYLOAD_BUDGET / 4);

    logic [TS_W-1:0]   ts_reg;
    logic [XW-1:0]     width_reg;
    logic [BPP_W-1:0]  bpp_reg;
    logic [LEN_W-1:0]  maxpix_reg;
    logic [ROW_W-1:0]  row_reg;
    logic              last_line_reg;
    logic [OFS_W-1:0]  prod_reg;
    logic [OFS_W-1:0]  offset_reg;
    logic [XW-1:0]     x_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [SEQ_W-1:0]  seq_reg;
    logic [ROW_W-1:0]  line_cnt_reg;
    logic              out_valid_reg;

    logic [XW-1:0]     width_eff;
    logic [HW-1:0]     height_eff;
    logic [BPP_W-1:0]  bpp_eff;
    logic [LEN_W-1:0]  maxpix_eff;

    logic [OFS_W-1:0]  mul_a;
    logic [XW-1:0]     mul_b;
    logic [OFS_W+XW-1:0] mul_res;

    logic [XW-1:0]     remain;
    logic [LEN_W-1:0]  pixels;
    logic [LEN_W-1:0]  bytes;
    logic [XW-1:0]     x_end;
    logic              eol;

    // Clamp the geometry registers when a line is taken.
    always_comb
    begin
        if (XW'(cfg.frame_width) > XW'(MAX_WIDTH))
            width_eff = XW'(MAX_WIDTH);
        else
            width_eff = XW'(cfg.frame_width);

        if (cfg.frame_height == '0)
            height_eff = HW'(1);
        else if (HW'(cfg.frame_height) > HW'(MAX_HEIGHT))
            height_eff = HW'(MAX_HEIGHT);
        else
            height_eff = HW'(cfg.frame_height);

        if (cfg.bpp == '0)
            bpp_eff = BPP_W'(2);
        else if (cfg.bpp > BPP_W'(4))
            bpp_eff = BPP_W'(4);
        else
            bpp_eff = cfg.bpp;

        case (bpp_eff)
            BPP_W'(1): maxpix_eff = MP1;
            BPP_W'(2): maxpix_eff = MP2;
            BPP_W'(3): maxpix_eff = MP3;
            default:   maxpix_eff = MP4;
        endcase
    end

    // Packet size for the current pixel position.
    assign remain = width_reg - x_reg;
    assign pixels = (remain > XW'(maxpix_reg)) ? maxpix_reg : remain[LEN_W-1:0];
    assign x_end  = x_reg + XW'(pixels);
    assign eol    = (x_end == width_reg);

    // The one multiplier: row times width, then times pixel size, then the
    // byte count of each packet.
    always_comb
    begin
        if (ctrl.row_mul)
        begin
            mul_a = OFS_W'(row_reg);
            mul_b = width_reg;
        end
        else if (ctrl.base_mul)
        begin
            mul_a = prod_reg;
            mul_b = XW'(bpp_reg);
        end
        else
        begin
            mul_a = OFS_W'(pixels);
            mul_b = XW'(bpp_reg);
        end
    end

    assign mul_res = (OFS_W + XW)'(mul_a) * (OFS_W + XW)'(mul_b);
    assign bytes   = mul_res[LEN_W-1:0];

    assign stat.more      = (x_reg < width_reg) && (count_reg != CNT_W'(MAX_PACKETS));
    assign stat.out_space = !out_valid_reg || pkt.ready;

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            ts_reg        <= frame_timestamp;
            width_reg     <= width_eff;
            bpp_reg       <= bpp_eff;
            maxpix_reg    <= maxpix_eff;
            row_reg       <= line_cnt_reg;
            last_line_reg <= HW'(line_cnt_reg) >= (height_eff - HW'(1));
        end
        if (ctrl.row_mul)
            prod_reg <= mul_res[OFS_W-1:0];
        if (ctrl.emit)
        begin
            pkt.marker         <= last_line_reg && eol;
            pkt.seq_low        <= seq_reg[HALF_W-1:0];
            pkt.seq_high       <= seq_reg[SEQ_W-1:HALF_W];
            pkt.timestamp      <= ts_reg;
            pkt.payload_length <= bytes;
            pkt.line_number    <= row_reg;
            pkt.pixel_offset   <= x_reg[POS_W-1:0];
            pkt.source_offset  <= offset_reg;
            pkt.packet_bytes   <= bytes + LEN_W'(HEADER_BYTES);
            pkt.last_of_line   <= eol || (count_reg == CNT_W'(MAX_PACKETS - 1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg         <= '0;
            count_reg     <= '0;
            offset_reg    <= '0;
            seq_reg       <= '0;
            line_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.accept)
            begin
                x_reg     <= '0;
                count_reg <= '0;
            end
            if (ctrl.base_mul)
                offset_reg <= mul_res[OFS_W-1:0];
            if (ctrl.emit)
            begin
                x_reg      <= x_end;
                count_reg  <= count_reg + CNT_W'(1);
                offset_reg <= offset_reg + OFS_W'(bytes);
                seq_reg    <= seq_reg + SEQ_W'(1);
            end
            if (ctrl.finish)
                line_cnt_reg <= last_line_reg ? '0 : row_reg + ROW_W'(1);

            if (ctrl.emit)
                out_valid_reg <= 1'b1;
            else if (pkt.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign pkt.valid = out_valid_reg;

endmodule

`default_nettype wire

### rtl/video_line_rtp_packetizer_core.sv
// ----------------------------------------------------------------------------
// video_line_rtp_packetizer_core
// Cuts each video line into RTP packets and emits one header per packet.
// ----------------------------------------------------------------------------
// Each line request carries the frame timestamp. The block takes one line at
// a time: after a line is accepted it uses the shared multiplier in the row
// and base multiply states to form the line's byte offset, then emits one
// header per packet, up to twelve packets per line (three for 1920 pixels of
// two bytes), and closes the line. A packet waits while the packet channel
// has no space. The multiplier is shared between the offset setup and the
// per-packet byte count. Headers leave through an output register, so the
// next line is taken while the last header of the previous one still waits.
// A zero-width line gives no packets but still advances the line counter.
`default_nettype none

module video_line_rtp_packetizer_core
    import vlrp_pkg::*;
#(
    parameter int MAX_WIDTH      = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT     = DEF_MAX_HEIGHT,
    parameter int PAYLOAD_BUDGET = DEF_PAYLOAD_BUDGET
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    vlrp_line_if.sink                  line,
    vlrp_pkt_if.source                 pkt
);

    cfg_t  cfg;
    ctrl_t ctrl;
    stat_t stat;

    assign pready = 1'b1;

    vlrp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    vlrp_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (line.valid),
        .in_ready (line.ready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    vlrp_dp #(
        .MAX_WIDTH      (MAX_WIDTH),
        .MAX_HEIGHT     (MAX_HEIGHT),
        .PAYLOAD_BUDGET (PAYLOAD_BUDGET)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .ctrl            (ctrl),
        .stat            (stat),
        .frame_timestamp (line.frame_timestamp),
        .pkt             (pkt)
    );

endmodule

`default_nettype wire

### rtl/vlrp_checker.sv
// ----------------------------------------------------------------------------
// vlrp_checker
// Port-level checks of the packetizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vlrp_checker
    import vlrp_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic              marker,
    input wire logic              last_of_line,
    input wire logic [HALF_W-1:0] seq_low,
    input wire logic [LEN_W-1:0]  payload_length,
    input wire logic [LEN_W-1:0]  packet_bytes
);

    // A line request keeps the sequencer busy for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("line accepted while previous line still in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(seq_low)))
        else $error("stalled packet request changed");

    // The frame's final packet is always the final packet of its line.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && marker) |-> last_of_line)
        else $error("marker without end of line");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (packet_bytes == payload_length + LEN_W'(HEADER_BYTES)))
        else $error("packet size does not match payload length");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (payload_length != '0))
        else $error("empty packet emitted");

endmodule

bind video_line_rtp_packetizer_core vlrp_checker u_vlrp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (line.valid),
    .in_ready       (line.ready),
    .out_valid      (pkt.valid),
    .out_ready      (pkt.ready),
    .marker         (pkt.marker),
    .last_of_line   (pkt.last_of_line),
    .seq_low        (pkt.seq_low),
    .payload_length (pkt.payload_length),
    .packet_bytes   (pkt.packet_bytes)
);

`default_nettype wire
